### rtl/tbn_pkg.sv
// Shared types and constants for the triangle tangent frame pipeline.
`timescale 1ns / 1ps

package tbn_pkg;

  // Field widths
  localparam int unsigned COORD_W    = 24;
  localparam int unsigned EDGE_W     = COORD_W + 1;
  localparam int unsigned UNIT_W     = 16;
  localparam int unsigned VEC_N      = 3;
  localparam int unsigned IN_DATA_W  = 3 * VEC_N * COORD_W;
  localparam int unsigned OUT_DATA_W = 3 * VEC_N * UNIT_W;

  // Cross product result widths
  localparam int unsigned CROSS_N_W  = 2 * EDGE_W + 1;
  localparam int unsigned CROSS_T_W  = UNIT_W + EDGE_W + 1;
  localparam int unsigned CROSS_B_W  = 2 * UNIT_W + 1;

  // Normalization precision
  localparam int unsigned NORM_BITS  = 30;
  localparam int unsigned FRAC_BITS  = 14;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // One classified triangle handed from front to back
  typedef struct packed {
    logic signed [CROSS_N_W-1:0] cr_z;
    logic signed [CROSS_N_W-1:0] cr_y;
    logic signed [CROSS_N_W-1:0] cr_x;
    logic signed [EDGE_W-1:0]    e2_z;
    logic signed [EDGE_W-1:0]    e2_y;
    logic signed [EDGE_W-1:0]    e2_x;
    logic                        degen;
    logic                        last;
  } tbn_item_t;

endpackage

### rtl/tbn_cross.sv
// Two-stage pipelined cross product with sideband carry.
`timescale 1ns / 1ps

module tbn_cross #(
  parameter int unsigned AW = 16,
  parameter int unsigned BW = 16,
  parameter int unsigned XW = 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  logic signed [AW-1:0]   p_i [3],
  input  logic signed [BW-1:0]   q_i [3],
  input  logic [XW-1:0]          x_i,
  output logic                   vld_o,
  output logic signed [AW+BW:0]  o_o [3],
  output logic [XW-1:0]          x_o
);

  localparam int unsigned PW = AW + BW;
  localparam int unsigned OW = PW + 1;

  logic signed [PW-1:0] pr_d [6];
  logic signed [PW-1:0] pr_q [6];
  logic signed [OW-1:0] o_d [3];
  logic signed [OW-1:0] o_q [3];
  logic                 vl_q [2];
  logic [XW-1:0]        x_q [2];

  // Form the six partial products
  always_comb begin
    pr_d[0] = PW'(p_i[1]) * PW'(q_i[2]);
    pr_d[1] = PW'(p_i[2]) * PW'(q_i[1]);
    pr_d[2] = PW'(p_i[2]) * PW'(q_i[0]);
    pr_d[3] = PW'(p_i[0]) * PW'(q_i[2]);
    pr_d[4] = PW'(p_i[0]) * PW'(q_i[1]);
    pr_d[5] = PW'(p_i[1]) * PW'(q_i[0]);
  end

  // Subtract the product pairs
  always_comb begin
    o_d[0] = OW'(pr_q[0]) - OW'(pr_q[1]);
    o_d[1] = OW'(pr_q[2]) - OW'(pr_q[3]);
    o_d[2] = OW'(pr_q[4]) - OW'(pr_q[5]);
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vl_q[0] <= 1'b0;
      vl_q[1] <= 1'b0;
    end else if (en_i) begin
      vl_q[0] <= vld_i;
      vl_q[1] <= vl_q[0];
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q <= pr_d;
      o_q  <= o_d;
      x_q[0] <= x_i;
      x_q[1] <= x_q[0];
    end
  end

  assign vld_o = vl_q[1];
  assign o_o   = o_q;
  assign x_o   = x_q[1];

endmodule

### rtl/tbn_unit.sv
// Pipelined vector normalizer: magnitude, shift search, root and divide stages.
`timescale 1ns / 1ps

module tbn_unit #(
  parameter int unsigned InW = 51,
  parameter int unsigned XW  = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              vld_i,
  input  logic signed [InW-1:0]             v_i [3],
  input  logic [XW-1:0]                     x_i,
  output logic                              vld_o,
  output logic signed [tbn_pkg::UNIT_W-1:0] u_o [3],
  output logic [XW-1:0]                     x_o
);

  localparam int unsigned NB  = tbn_pkg::NORM_BITS;
  localparam int unsigned FB  = tbn_pkg::FRAC_BITS;
  localparam int unsigned UW  = tbn_pkg::UNIT_W;
  localparam int unsigned NS  = $clog2(InW);
  localparam int unsigned SQW = 2 * NB;
  localparam int unsigned SMW = SQW + 2;
  localparam int unsigned TW  = SMW + 2;
  localparam int unsigned RW  = NB + 1;
  localparam int unsigned DW  = NB + FB + 2;
  localparam int unsigned QW  = FB + 1;
  localparam int unsigned SDW = XW + 3;
  localparam int unsigned LAT = NS + RW + QW + 6;

  // Valid and sideband (signs over the extra bits) for every stage
  logic           vl_q [LAT];
  logic [SDW-1:0] sd_q [LAT];
  logic [SDW-1:0] sd0_d;

  // Magnitude and maximum
  logic [InW-1:0] mag_d [3];
  logic [InW-1:0] mag_q [3];
  logic [InW-1:0] mx_d;

  // Shift search: index 0 holds the max stage
  logic [InW-1:0] nm_q [NS+1][3];
  logic [InW-1:0] nx_q [NS+1];
  logic [InW-1:0] nm_d [NS][3];
  logic [InW-1:0] nx_d [NS];

  // Top bits and squares
  logic [NB-1:0]  sm_d [3];
  logic [NB-1:0]  sm_q [3];
  logic [SQW-1:0] sqp_d [3];
  logic [SQW-1:0] sqp_q [3];
  logic [SMW-1:0] rem0_d;

  // Square root: index 0 holds the sum stage
  logic [SMW-1:0] rem_q [RW+1];
  logic [RW-1:0]  rt_q [RW+1];
  logic [NB-1:0]  rs_q [RW+1][3];
  logic [SMW-1:0] rem_d [RW];
  logic [RW-1:0]  rt_d [RW];

  // Divide: index 0 holds the numerator stage
  logic [DW-1:0]  dr_q [QW+1][3];
  logic [QW-1:0]  dq_q [QW+1][3];
  logic [RW-1:0]  dd_q [QW+1];
  logic [DW-1:0]  dr0_d [3];
  logic [DW-1:0]  dr_d [QW][3];
  logic [QW-1:0]  dq_d [QW][3];

  logic signed [UW-1:0] u_d [3];
  logic signed [UW-1:0] u_q [3];

  assign sd0_d = {v_i[2][InW-1], v_i[1][InW-1], v_i[0][InW-1], x_i};

  // Take magnitudes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_d[k] = v_i[k][InW-1] ? $unsigned(InW'(-v_i[k])) : $unsigned(v_i[k]);
    end
  end

  // Pick the largest magnitude
  always_comb begin
    mx_d = mag_q[0];
    if (mag_q[1] > mx_d) begin
      mx_d = mag_q[1];
    end
    if (mag_q[2] > mx_d) begin
      mx_d = mag_q[2];
    end
  end

  // Shift left by halving steps until the maximum has its top bit set
  always_comb begin
    for (int j = 0; j < NS; j++) begin
      if ((nx_q[j] >> (InW - (1 << (NS - 1 - j)))) == '0) begin
        nx_d[j] = nx_q[j] << (1 << (NS - 1 - j));
        for (int k = 0; k < 3; k++) begin
          nm_d[j][k] = nm_q[j][k] << (1 << (NS - 1 - j));
        end
      end else begin
        nx_d[j] = nx_q[j];
        for (int k = 0; k < 3; k++) begin
          nm_d[j][k] = nm_q[j][k];
        end
      end
    end
  end

  // Keep the top bits and square them
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sm_d[k]  = nm_q[NS][k][InW-1 -: NB];
      sqp_d[k] = SQW'(sm_d[k]) * SQW'(sm_d[k]);
    end
    rem0_d = SMW'(sqp_q[0]) + SMW'(sqp_q[1]) + SMW'(sqp_q[2]);
  end

  // One root bit per stage
  always_comb begin
    logic [TW-1:0] t;
    for (int j = 0; j < RW; j++) begin
      t = (TW'(rt_q[j]) << (RW - j)) + (TW'(1) << (2 * (RW - 1 - j)));
      if (TW'(rem_q[j]) >= t) begin
        rem_d[j] = rem_q[j] - SMW'(t);
        rt_d[j]  = rt_q[j] | (RW'(1) << (RW - 1 - j));
      end else begin
        rem_d[j] = rem_q[j];
        rt_d[j]  = rt_q[j];
      end
    end
  end

  // Build rounded numerators
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dr0_d[k] = (DW'(rs_q[RW][k]) << FB) + DW'(rt_q[RW] >> 1);
    end
  end

  // One quotient bit per stage
  always_comb begin
    logic [DW-1:0] dv;
    for (int j = 0; j < QW; j++) begin
      dv = DW'(dd_q[j]) << (QW - 1 - j);
      for (int k = 0; k < 3; k++) begin
        if (dr_q[j][k] >= dv) begin
          dr_d[j][k] = dr_q[j][k] - dv;
          dq_d[j][k] = dq_q[j][k] | (QW'(1) << (QW - 1 - j));
        end else begin
          dr_d[j][k] = dr_q[j][k];
          dq_d[j][k] = dq_q[j][k];
        end
      end
    end
  end

  // Reapply signs; zero vector stays zero
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dd_q[QW] == '0) begin
        u_d[k] = '0;
      end else if (sd_q[LAT-2][XW+k]) begin
        u_d[k] = UW'(0) - UW'(dq_q[QW][k]);
      end else begin
        u_d[k] = UW'(dq_q[QW][k]);
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) begin
        vl_q[i] <= 1'b0;
      end
    end else if (en_i) begin
      vl_q[0] <= vld_i;
      for (int i = 1; i < LAT; i++) begin
        vl_q[i] <= vl_q[i-1];
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q[0] <= sd0_d;
      for (int i = 1; i < LAT; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
      mag_q    <= mag_d;
      nx_q[0]  <= mx_d;
      nm_q[0]  <= mag_q;
      for (int j = 0; j < NS; j++) begin
        nx_q[j+1] <= nx_d[j];
        nm_q[j+1] <= nm_d[j];
      end
      sm_q     <= sm_d;
      sqp_q    <= sqp_d;
      rem_q[0] <= rem0_d;
      rt_q[0]  <= '0;
      rs_q[0]  <= sm_q;
      for (int j = 0; j < RW; j++) begin
        rem_q[j+1] <= rem_d[j];
        rt_q[j+1]  <= rt_d[j];
        rs_q[j+1]  <= rs_q[j];
      end
      dr_q[0] <= dr0_d;
      for (int k = 0; k < 3; k++) begin
        dq_q[0][k] <= '0;
      end
      dd_q[0] <= rt_q[RW];
      for (int j = 0; j < QW; j++) begin
        dr_q[j+1] <= dr_d[j];
        dq_q[j+1] <= dq_d[j];
        dd_q[j+1] <= dd_q[j];
      end
      u_q <= u_d;
    end
  end

  assign vld_o = vl_q[LAT-1];
  assign x_o   = sd_q[LAT-1][XW-1:0];
  assign u_o   = u_q;

endmodule

### rtl/tbn_fifo.sv
// Small queue of classified triangles between front and back.
`timescale 1ns / 1ps

module tbn_fifo #(
  parameter int unsigned Depth = tbn_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tbn_pkg::tbn_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output tbn_pkg::tbn_item_t item_o,
  output logic               empty_o
);

  localparam int unsigned PW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  tbn_pkg::tbn_item_t mem_q [Depth];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  // Step pointers and count
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(Depth - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(Depth - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign item_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);

endmodule

### rtl/tbn_front.sv
// Front end: take triangles, form edges and the face cross product, flag degenerates.
`timescale 1ns / 1ps

module tbn_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_vld_i,
  output logic                              in_rdy_o,
  input  logic [tbn_pkg::IN_DATA_W-1:0]     in_data_i,
  input  logic                              in_last_i,
  output logic                              vld_o,
  input  logic                              rdy_i,
  output tbn_pkg::tbn_item_t                item_o
);

  localparam int unsigned CW = tbn_pkg::COORD_W;
  localparam int unsigned EW = tbn_pkg::EDGE_W;
  localparam int unsigned NW = tbn_pkg::CROSS_N_W;
  localparam int unsigned XW = 3 * EW + 1;

  logic signed [CW-1:0] crd [9];
  logic signed [EW-1:0] e1_d [3];
  logic signed [EW-1:0] e2_d [3];
  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic                 lt_q;
  logic                 ev_q;
  logic                 en;
  logic signed [NW-1:0] cr [3];
  logic [XW-1:0]        cx;

  assign en       = !vld_o || rdy_i;
  assign in_rdy_o = en;

  // Split coordinates and form edges
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      crd[i] = in_data_i[i*CW +: CW];
    end
    for (int k = 0; k < 3; k++) begin
      e1_d[k] = EW'(crd[3+k]) - EW'(crd[k]);
      e2_d[k] = EW'(crd[6+k]) - EW'(crd[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q <= 1'b0;
    end else if (en) begin
      ev_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_q <= e1_d;
      e2_q <= e2_d;
      lt_q <= in_last_i;
    end
  end

  // Face cross product, edge two rides along
  tbn_cross #(
    .AW (EW),
    .BW (EW),
    .XW (XW)
  ) u_cross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (ev_q),
    .p_i    (e1_q),
    .q_i    (e2_q),
    .x_i    ({e2_q[2], e2_q[1], e2_q[0], lt_q}),
    .vld_o  (vld_o),
    .o_o    (cr),
    .x_o    (cx)
  );

  // Classify and pack
  always_comb begin
    item_o.cr_x  = cr[0];
    item_o.cr_y  = cr[1];
    item_o.cr_z  = cr[2];
    item_o.e2_x  = cx[1 +: EW];
    item_o.e2_y  = cx[1+EW +: EW];
    item_o.e2_z  = cx[1+2*EW +: EW];
    item_o.last  = cx[0];
    item_o.degen = (cr[0] == '0) && (cr[1] == '0) && (cr[2] == '0);
  end

endmodule

### rtl/tbn_back.sv
// Back end: normalize the normal, build and normalize tangent and binormal.
`timescale 1ns / 1ps

module tbn_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           vld_i,
  input  tbn_pkg::tbn_item_t             item_i,
  output logic                           pop_o,
  output logic                           out_vld_o,
  input  logic                           out_rdy_i,
  output logic [tbn_pkg::OUT_DATA_W-1:0] out_data_o,
  output logic                           out_last_o,
  output logic                           out_degen_o
);

  localparam int unsigned EW  = tbn_pkg::EDGE_W;
  localparam int unsigned UW  = tbn_pkg::UNIT_W;
  localparam int unsigned NW  = tbn_pkg::CROSS_N_W;
  localparam int unsigned TW  = tbn_pkg::CROSS_T_W;
  localparam int unsigned BW  = tbn_pkg::CROSS_B_W;
  localparam int unsigned XNW = 3 * EW + 2;
  localparam int unsigned XTW = 3 * UW + 2;
  localparam int unsigned XBW = 6 * UW + 2;

  logic                 en;
  logic signed [NW-1:0] cr_v [3];
  logic signed [UW-1:0] nu [3];
  logic [XNW-1:0]       xn;
  logic signed [EW-1:0] e2 [3];
  logic                 nv;
  logic signed [TW-1:0] tc [3];
  logic [XTW-1:0]       xtc;
  logic                 tcv;
  logic signed [UW-1:0] tu [3];
  logic [XTW-1:0]       xt;
  logic                 tv;
  logic signed [BW-1:0] bc [3];
  logic [XBW-1:0]       xbc;
  logic                 bcv;
  logic signed [UW-1:0] bu [3];
  logic [XBW-1:0]       xb;
  logic                 bv;

  logic                         out_vld_q;
  logic [tbn_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                         out_last_q;
  logic                         out_degen_q;

  // Whole back pipe advances while the output register can take a result
  assign en    = !out_vld_q || out_rdy_i;
  assign pop_o = en && vld_i;

  assign cr_v[0] = item_i.cr_x;
  assign cr_v[1] = item_i.cr_y;
  assign cr_v[2] = item_i.cr_z;

  tbn_unit #(
    .InW (NW),
    .XW  (XNW)
  ) u_nrm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_i),
    .v_i    (cr_v),
    .x_i    ({item_i.e2_z, item_i.e2_y, item_i.e2_x, item_i.degen, item_i.last}),
    .vld_o  (nv),
    .u_o    (nu),
    .x_o    (xn)
  );

  assign e2[0] = xn[2 +: EW];
  assign e2[1] = xn[2+EW +: EW];
  assign e2[2] = xn[2+2*EW +: EW];

  // Tangent direction: normal x edge two
  tbn_cross #(
    .AW (UW),
    .BW (EW),
    .XW (XTW)
  ) u_tcross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (nv),
    .p_i    (nu),
    .q_i    (e2),
    .x_i    ({nu[2], nu[1], nu[0], xn[1:0]}),
    .vld_o  (tcv),
    .o_o    (tc),
    .x_o    (xtc)
  );

  tbn_unit #(
    .InW (TW),
    .XW  (XTW)
  ) u_tan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (tcv),
    .v_i    (tc),
    .x_i    (xtc),
    .vld_o  (tv),
    .u_o    (tu),
    .x_o    (xt)
  );

  logic signed [UW-1:0] nt [3];
  assign nt[0] = xt[2 +: UW];
  assign nt[1] = xt[2+UW +: UW];
  assign nt[2] = xt[2+2*UW +: UW];

  // Binormal direction: tangent x normal
  tbn_cross #(
    .AW (UW),
    .BW (UW),
    .XW (XBW)
  ) u_bcross (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (tv),
    .p_i    (tu),
    .q_i    (nt),
    .x_i    ({tu[2], tu[1], tu[0], xt}),
    .vld_o  (bcv),
    .o_o    (bc),
    .x_o    (xbc)
  );

  tbn_unit #(
    .InW (BW),
    .XW  (XBW)
  ) u_bin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (bcv),
    .v_i    (bc),
    .x_i    (xbc),
    .vld_o  (bv),
    .u_o    (bu),
    .x_o    (xb)
  );

  // Hold the finished result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= bv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q  <= {bu[2], bu[1], bu[0], xb[2 +: 6*UW]};
      out_last_q  <= xb[0];
      out_degen_q <= xb[1];
    end
  end

  assign out_vld_o   = out_vld_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;
  assign out_degen_o = out_degen_q;

endmodule

### rtl/triangle_tbn_frame.sv
// Top level: per-triangle unit normal, tangent and binormal.
//
//  channel  dir  tdata                               tlast     tuser
//  s_axis   in   a_x a_y a_z b_x b_y b_z c_x c_y c_z  last_tri  -
//  m_axis   out  nrm_xyz tan_xyz bin_xyz             last_out  degenerate
//
// Takes one triangle per cycle while the queue is not full; each result passes
// the front, the queue, the three normalizer pipes (58 stages each: shift
// search, a 31-step square root and a 15-step divide) and the cross product pipes.
// Reset clears only valid bits, queue pointers and the queue count; no clearing pass.
// An output stall freezes the back pipe; the front keeps taking triangles
// until the queue and the front stages are full.
`timescale 1ns / 1ps

module triangle_tbn_frame #(
  parameter int unsigned QueueDepth = tbn_pkg::QUEUE_DEPTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (24 bits each, low first)
  input  logic [tbn_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // nrm_x, nrm_y, nrm_z, tan_x, tan_y, tan_z, bin_x, bin_y, bin_z (16 bits each)
  output logic [tbn_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast,
  // degenerate
  output logic                           m_axis_tuser
);

  logic               f_vld;
  logic               q_full;
  logic               q_empty;
  logic               q_push;
  logic               q_pop;
  tbn_pkg::tbn_item_t f_item;
  tbn_pkg::tbn_item_t q_item;

  assign q_push = f_vld && !q_full;

  tbn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (s_axis_tvalid),
    .in_rdy_o  (s_axis_tready),
    .in_data_i (s_axis_tdata),
    .in_last_i (s_axis_tlast),
    .vld_o     (f_vld),
    .rdy_i     (!q_full),
    .item_o    (f_item)
  );

  tbn_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .empty_o (q_empty)
  );

  tbn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (!q_empty),
    .item_i      (q_item),
    .pop_o       (q_pop),
    .out_vld_o   (m_axis_tvalid),
    .out_rdy_i   (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_degen_o (m_axis_tuser)
  );

`ifndef SYNTHESIS
  logic signed [tbn_pkg::UNIT_W-1:0] nrm_x_chk;
  assign nrm_x_chk = m_axis_tdata[tbn_pkg::UNIT_W-1:0];

  // A degenerate triangle carries an all-zero frame
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate transaction with nonzero vectors");

  // A stalled output freezes the back pipe, so the queue is not drained
  a_stall_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !q_pop)
    else $error("queue popped while output stalled");

  // The normal's x component stays within one in Q1.14
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (nrm_x_chk <= 16'sd16384) && (nrm_x_chk >= -16'sd16384))
    else $error("normal x out of unit range");
`endif

endmodule

### dv/tb_top.sv
// Self-checking testbench for the triangle tangent frame pipeline.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NumRandom  = 930;
  localparam int unsigned Latency    = 200;
  localparam int unsigned CycleLimit = 400000;

  typedef logic signed [tbn_pkg::COORD_W-1:0] coord_t;
  typedef logic signed [tbn_pkg::UNIT_W-1:0]  unit_t;

  typedef struct {
    coord_t pos[9];
    logic   last;
  } tri_t;

  typedef struct {
    unit_t v[9];
    logic  last;
    logic  degen;
  } frame_t;

  typedef struct {
    tri_t   tri_in;
    logic   known;
    frame_t frm;
  } row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [tbn_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           s_axis_tlast;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [tbn_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           m_axis_tuser;

  frame_t  frames_due[$];
  row_t    vectors[$];
  int      errors;
  longint  cycles = 0;
  bit      stall_mode;
  string   fld_name[9] = '{"nrm_x", "nrm_y", "nrm_z", "tan_x", "tan_y", "tan_z",
                           "bin_x", "bin_y", "bin_z"};

  triangle_tbn_frame u_top (.*);

  // Generate clock
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Square root by bit pairs
  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale to unit length in Q1.14
  function automatic void unit_vec(input longint v[3], output longint o[3]);
    longint unsigned mg[3];
    longint unsigned m;
    longint unsigned sq;
    longint unsigned len;
    longint unsigned q;
    int bl;
    m = 0;
    sq = 0;
    bl = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
      if (mg[i] > m) m = mg[i];
    end
    if (m == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return;
    end
    while (bl < 63 && (m >> bl) != 0) bl++;
    for (int i = 0; i < 3; i++) begin
      if (bl > 30) mg[i] >>= (bl - 30);
      else mg[i] <<= (30 - bl);
      sq += mg[i] * mg[i];
    end
    len = root64(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((mg[i] << 14) + (len >> 1)) / len;
      o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross3(input longint p[3], input longint q[3], output longint o[3]);
    o[0] = p[1] * q[2] - p[2] * q[1];
    o[1] = p[2] * q[0] - p[0] * q[2];
    o[2] = p[0] * q[1] - p[1] * q[0];
  endfunction

  // Compute normal, tangent and binormal of one triangle
  function automatic frame_t tbn_frame(tri_t t);
    frame_t f;
    longint e1[3], e2[3], cr[3], nv[3], tv[3], bv[3], tmp[3];
    for (int i = 0; i < 3; i++) begin
      e1[i] = longint'(t.pos[3 + i]) - longint'(t.pos[i]);
      e2[i] = longint'(t.pos[6 + i]) - longint'(t.pos[i]);
    end
    cross3(e1, e2, cr);
    f.degen = (cr[0] == 0 && cr[1] == 0 && cr[2] == 0);
    unit_vec(cr, nv);
    cross3(nv, e2, tmp);
    unit_vec(tmp, tv);
    cross3(tv, nv, tmp);
    unit_vec(tmp, bv);
    for (int i = 0; i < 3; i++) begin
      f.v[i]     = unit_t'(nv[i]);
      f.v[3 + i] = unit_t'(tv[i]);
      f.v[6 + i] = unit_t'(bv[i]);
    end
    f.last = t.last;
    return f;
  endfunction

  // Field by field comparison of two frames
  function automatic bit same_frame(frame_t a, frame_t b);
    bit ok;
    ok = (a.last === b.last) && (a.degen === b.degen);
    for (int i = 0; i < 9; i++) begin
      if (a.v[i] !== b.v[i]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic tri_t mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                  int cx, int cy, int cz, logic l);
    tri_t t;
    t.pos = '{coord_t'(ax), coord_t'(ay), coord_t'(az), coord_t'(bx), coord_t'(by),
              coord_t'(bz), coord_t'(cx), coord_t'(cy), coord_t'(cz)};
    t.last = l;
    return t;
  endfunction

  function automatic coord_t rnd_coord(int kind);
    case (kind)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(0, 512)) - 256);
      2: return $urandom_range(0, 1) ? coord_t'(24'h7FFFFF) : coord_t'(24'h800000);
      default: return coord_t'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
    endcase
  endfunction

  function automatic tri_t rnd_tri();
    tri_t t;
    int kind;
    int sel;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) t.pos[i] = rnd_coord($urandom_range(0, 7) == 0 ? 2 : kind);
    sel = $urandom_range(0, 19);
    // Make some triangles degenerate: repeated vertex or collinear points
    if (sel == 0) begin
      for (int i = 0; i < 3; i++) t.pos[3 + i] = t.pos[i];
    end else if (sel == 1) begin
      for (int i = 0; i < 3; i++) t.pos[6 + i] = t.pos[3 + i];
    end else if (sel == 2) begin
      for (int i = 0; i < 3; i++) begin
        t.pos[3 + i] = t.pos[i] + coord_t'(i + 1);
        t.pos[6 + i] = t.pos[i] + coord_t'(2 * (i + 1));
      end
    end
    t.last = ($urandom_range(0, 7) == 0);
    return t;
  endfunction

  // Send one triangle; hold until accepted
  task automatic send_tri(tri_t t);
    logic [tbn_pkg::IN_DATA_W-1:0] data;
    frames_due.push_back(tbn_frame(t));
    for (int i = 0; i < 9; i++) data[i*tbn_pkg::COORD_W +: tbn_pkg::COORD_W] = t.pos[i];
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tlast  <= t.last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    int gap;
    if ($urandom_range(0, 3) != 0) return;
    s_axis_tvalid <= 1'b0;
    gap = $urandom_range(1, 6);
    repeat (gap) @(negedge clk_i);
  endtask

  // Receiver stall pattern: alternate between free-flowing and choppy stretches
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    m_axis_tready <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b1;
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    frame_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frames_due.size() == 0) begin
        $error("result with no triangle pending");
        errors++;
      end else begin
        want = frames_due.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (m_axis_tdata[i*tbn_pkg::UNIT_W +: tbn_pkg::UNIT_W] !== want.v[i]) begin
            $error("%s: expected %0d, actual %0d", fld_name[i], want.v[i],
                   $signed(m_axis_tdata[i*tbn_pkg::UNIT_W +: tbn_pkg::UNIT_W]));
            errors++;
          end
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_out: expected %0b, actual %0b", want.last, m_axis_tlast);
          errors++;
        end
        if (m_axis_tuser !== want.degen) begin
          $error("degenerate: expected %0b, actual %0b", want.degen, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_row(tri_t t, logic known, frame_t f);
    row_t r;
    r.tri_in = t;
    r.known = known;
    r.frm = f;
    vectors.push_back(r);
  endtask

  initial begin
    frame_t f0;
    frame_t fz;
    errors = 0;
    stall_mode = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    for (int i = 0; i < 9; i++) fz.v[i] = '0;
    fz.last = 1'b0;
    fz.degen = 1'b1;
    f0 = fz;
    f0.degen = 1'b0;
    // Axis-aligned right triangle in the xy plane: normal +z, tangent -x, binormal +y
    f0.v = '{unit_t'(0), unit_t'(0), unit_t'(16384), unit_t'(-16384), unit_t'(0),
             unit_t'(0), unit_t'(0), unit_t'(16384), unit_t'(0)};

    // Directed table: degenerate cases, extremes, axis cases
    add_row(mk_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, fz);
    fz.last = 1'b1;
    add_row(mk_tri(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608,
                   -8388608, -8388608, -8388608, 1), 1'b1, fz);
    fz.last = 1'b0;
    add_row(mk_tri(8388607, 8388607, 8388607, 8388607, 8388607, 8388607,
                   8388607, 8388607, 8388607, 0), 1'b1, fz);
    add_row(mk_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0), 1'b0, f0);
    add_row(mk_tri(0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0), 1'b1, f0);
    add_row(mk_tri(0, 0, 0, 1, 1, 1, 2, 2, 2, 0), 1'b1, fz);
    add_row(mk_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 1), 1'b0, f0);
    add_row(mk_tri(-8388608, -8388608, -8388608, 8388607, -8388608, -8388608,
                   -8388608, 8388607, -8388608, 0), 1'b0, f0);
    add_row(mk_tri(8388607, 8388607, 8388607, -8388608, 8388607, -8388608,
                   8388607, -8388608, -8388608, 1), 1'b0, f0);
    add_row(mk_tri(-8388608, 8388607, 0, 8388607, -8388608, 0,
                   0, 0, 8388607, 0), 1'b0, f0);
    add_row(mk_tri(1, 2, 3, -5, 7, -11, 13, -17, 19, 0), 1'b0, f0);
    add_row(mk_tri(0, 0, 0, 0, 0, 1, 0, 0, 8388607, 0), 1'b0, f0);
    add_row(mk_tri(0, 0, 0, 0, 1, 0, 1, 0, 0, 1), 1'b0, f0);
    add_row(mk_tri(0, 0, 0, 8388607, 0, 0, 1, 1, 0, 0), 1'b0, f0);
    add_row(mk_tri(0, 0, 0, -1, 0, 0, 0, 0, -1, 0), 1'b0, f0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (vectors[k]) begin
      if (vectors[k].known) begin
        if (!same_frame(tbn_frame(vectors[k].tri_in), vectors[k].frm)) begin
          $error("directed row %0d: table disagrees with prediction", k);
          errors++;
        end
      end
      send_tri(vectors[k].tri_in);
      idle_gap();
    end

    // Drain everything before going on
    s_axis_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk_i);

    // Random bursts with random gaps
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) begin
        s_axis_tvalid <= 1'b0;
        while (frames_due.size() != 0) @(negedge clk_i);
      end
      send_tri(rnd_tri());
      if (n % 100 > 40) idle_gap();
    end
    s_axis_tvalid <= 1'b0;

    while (frames_due.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### triangle_tbn_frame.f
rtl/tbn_pkg.sv
rtl/tbn_cross.sv
rtl/tbn_unit.sv
rtl/tbn_fifo.sv
rtl/tbn_front.sv
rtl/tbn_back.sv
rtl/triangle_tbn_frame.sv
dv/tb_top.sv
